>>> rtl/rfd_pkg.sv
// shared types and constants for the radar frame deframer
`default_nettype none

package rfd_pkg;

    localparam int unsigned FRAME_LEN = 15;
    localparam int unsigned WIN_DEPTH = FRAME_LEN - 1;
    localparam int unsigned FILL_W    = $clog2(FRAME_LEN);

    localparam logic [7:0] HDR_BYTE0 = 8'hAA;
    localparam logic [7:0] HDR_BYTE1 = 8'h55;
    localparam logic [7:0] FTR_BYTE0 = 8'h0D;
    localparam logic [7:0] FTR_BYTE1 = 8'h0A;
    localparam logic [7:0] FLAG_ON   = 8'h01;

    localparam logic [11:0] DIST_STEP = 12'd15;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

    // payload bytes of a matched frame
    typedef struct packed {
        logic [7:0] mag_hi;    // frame byte 8
        logic [7:0] mag_lo;    // frame byte 7
        logic [7:0] motion;    // frame byte 6
        logic [7:0] dist_code; // frame byte 5
        logic [7:0] heart;     // frame byte 4
        logic [7:0] resp;      // frame byte 3
        logic [7:0] presence;  // frame byte 2
    } rfd_frame_t;

    // decoded record, presence in the lowest bit
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] motion_magnitude;
        logic        motion;
        logic [11:0] distance_high;
        logic [11:0] distance_low;
        logic [7:0]  distance_code;
        logic [7:0]  pulse_rate;
        logic [7:0]  breath_rate;
        logic        presence;
    } rfd_rec_t;

endpackage

`default_nettype wire

>>> rtl/radar_frame_deframer.sv
// top level: byte input register, window match and decode, record output register
// the footer beat passes the input register; its match then loads the record register
// throughput: one byte beat per cycle while the record register is free or being drained
// set by the single pass from the input register through window match and decode
// reset: synchronous active-low aresetn empties the window count and both valid flags
// window contents are not cleared; the fill count masks stale bytes
`default_nettype none

module radar_frame_deframer
    import rfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // decoded records out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] presence, [8:1] breath_rate, [16:9] pulse_rate, [24:17] distance_code,
    // [36:25] distance_low, [48:37] distance_high, [49] motion,
    // [65:50] motion_magnitude, [71:66] zero
    output logic [71:0]      m_tdata
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // record register
    logic       out_vld_reg;
    rfd_rec_t   rec_reg;

    logic       advance;
    logic       hit;
    rfd_frame_t frame;
    rfd_rec_t   rec;

    // a held byte moves on when the record register can take a possible result
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    rfd_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (advance),
        .byte_in  (in_byte_reg),
        .hit      (hit),
        .frame    (frame)
    );

    rfd_decode u_decode (
        .frame (frame),
        .rec   (rec)
    );

    // input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    // input stage payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // output stage control: load on a match, drop when the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= hit;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge aclk) begin
        if (hit) begin
            rec_reg <= rec;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = rec_reg;

endmodule

`default_nettype wire

>>> rtl/rfd_window.sv
// sliding byte window with fill count and header and footer match
`default_nettype none

module rfd_window
    import rfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    output logic            hit,
    output rfd_frame_t      frame
);

    // newest byte enters at the top; when full, offset 0 is the oldest
    logic [7:0]        sr_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;
    logic              match;

    assign full  = (fill_reg == FILL_FULL);
    assign match = (sr_reg[0] == HDR_BYTE0) && (sr_reg[1] == HDR_BYTE1) &&
                   (sr_reg[WIN_DEPTH-1] == FTR_BYTE0) && (byte_in == FTR_BYTE1);
    assign hit   = shift_en && full && match;

    assign frame.presence  = sr_reg[2];
    assign frame.resp      = sr_reg[3];
    assign frame.heart     = sr_reg[4];
    assign frame.dist_code = sr_reg[5];
    assign frame.motion    = sr_reg[6];
    assign frame.mag_lo    = sr_reg[7];
    assign frame.mag_hi    = sr_reg[8];

    always_comb begin
        fill_next = fill_reg;
        if (shift_en) begin
            if (full) begin
                if (match) begin
                    fill_next = '0;
                end
            end else begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                sr_reg[i] <= sr_reg[i+1];
            end
            sr_reg[WIN_DEPTH-1] <= byte_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rfd_decode.sv
// decodes the payload bytes of a matched frame into a record
`default_nettype none

module rfd_decode
    import rfd_pkg::*;
(
    input  rfd_frame_t frame,
    output rfd_rec_t   rec
);

    logic [11:0] dist_hi;

    assign dist_hi = 12'(frame.dist_code) * DIST_STEP;

    always_comb begin
        rec                  = '0;
        rec.presence         = (frame.presence == FLAG_ON);
        rec.breath_rate      = frame.resp;
        rec.pulse_rate       = frame.heart;
        rec.distance_code    = frame.dist_code;
        rec.distance_high    = dist_hi;
        rec.distance_low     = (frame.dist_code != 8'd0) ? (dist_hi - DIST_STEP) : 12'd0;
        rec.motion           = (frame.motion == FLAG_ON);
        rec.motion_magnitude = {frame.mag_hi, frame.mag_lo};
    end

endmodule

`default_nettype wire

>>> rtl/rfd_checker.sv
// port-level checks for the radar frame deframer, bound to the top level
`default_nettype none

module rfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    logic [11:0] code_x15;

    assign code_x15 = 12'(m_tdata[24:17]) * 12'd15;

    // a stalled record beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("record beat changed while stalled");

    // nothing leaves straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("record beat valid after reset");

    // upper bound is the code in steps of fifteen
    a_dist_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[48:37] == code_x15)
        else $error("distance_high does not follow distance_code");

    // lower bound is one step below, or zero for code zero
    a_dist_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[24:17] == 8'd0) && (m_tdata[36:25] == 12'd0)) ||
                     ((m_tdata[24:17] != 8'd0) && (m_tdata[36:25] == code_x15 - 12'd15)))
        else $error("distance_low does not follow distance_code");

    // the byte input only backs up behind a stalled record beat
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("byte input stalled with no record waiting");

endmodule

bind radar_frame_deframer rfd_checker u_rfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
